### hw/rtl/clock_offset_window_stats_defines.svh
// Assertion macros for the clock offset window statistics block
`ifndef CLOCK_OFFSET_WINDOW_STATS_DEFINES_SVH
`define CLOCK_OFFSET_WINDOW_STATS_DEFINES_SVH
// implication checked on every edge outside reset
`define COWS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define COWS_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### hw/rtl/cows_pkg.sv
// Package: widths and constants of the window statistics block
package cows_pkg;
  localparam int WINDOW = 100;
  localparam int PTR_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int OFF_W = 28;
  localparam int TIME_W = 63;
  localparam int DRIFT_W = 39;
  localparam int JIT_W = 28;
  localparam int WCNT_W = 8;
  localparam int SUM_W = 36;
  localparam int SQ_W = 62;
  localparam int VAR_W = 70;
  localparam int MAG_W = 29;
  localparam int SQRT_W = 36;
  localparam logic [TIME_W-1:0] MIN_SPAN = TIME_W'(1000000);
  localparam logic [29:0] NS_PER_S = 30'd1000000000;
endpackage

### hw/rtl/cows_stream_if.sv
// Valid/ready stream interface carrying a packed payload
interface cows_stream_if #(parameter int W = 8) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/clock_offset_window_stats.sv
// Top level: sliding-window drift and jitter of clock offset samples
//
//  channel | direction | payload
//  in_s    | sink      | offset_ns[27:0], sample_time_ns[62:0]
//  out_s   | source    | drift_ppb[38:0], jitter_ns[27:0], window_count[7:0]
//
// The result is computed by serial units run in turn: three 36-bit multiplies,
// a 70-bit drift divide (skipped when the span rules out drift), a 35-step
// square root and a 70-bit jitter divide.
// Ring reads are registered. Reset is synchronous and clears control only.
// A result waits in the output register; the next sample is taken once out_s
// is free again.
module clock_offset_window_stats import cows_pkg::*; (
  input logic clk,
  input logic rst,
  cows_stream_if.sink in_s,
  cows_stream_if.source out_s
);
`include "clock_offset_window_stats_defines.svh"

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RDOLD = 12'b000000000010,
    S_UPD   = 12'b000000000100,
    S_RDOST = 12'b000000001000,
    S_WAIT  = 12'b000000010000,
    S_SQ1   = 12'b000000100000,
    S_SQ2   = 12'b000001000000,
    S_DIFF  = 12'b000010000000,
    S_DRIFT = 12'b000100000000,
    S_SQRT  = 12'b001000000000,
    S_JDIV  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;
  logic [OFF_W-1:0] offset_ring [WINDOW];
  logic [TIME_W-1:0] time_ring [WINDOW];
  logic [PTR_W-1:0] wptr, rd_addr;
  logic [CNT_W-1:0] count;
  logic signed [SUM_W-1:0] osum;
  logic [SQ_W-1:0] sqsum;
  logic signed [OFF_W-1:0] off_in, rd_off;
  logic [TIME_W-1:0] t_in, rd_time;
  logic signed [MAG_W-1:0] delta;
  logic [VAR_W-1:0] nsq, ssq, work;
  logic neg, span_ok;
  logic [DRIFT_W-1:0] drift;
  logic [JIT_W-1:0] jit;
  logic mul_start, mul_busy, mul_idle;
  logic div_start, div_busy, div_idle;
  logic sqrt_start, sqrt_busy, sqrt_idle;
  logic [VAR_W-1:0] ma, mp, dnum, dq;
  logic [SQRT_W-1:0] mb, root;
  logic [TIME_W-1:0] dden;
  logic signed [2*OFF_W-1:0] oldsq, newsq;
  logic [SUM_W-1:0] smag;
  logic full;

  assign full = (count == CNT_W'(WINDOW));
  assign oldsq = rd_off * rd_off;
  assign newsq = off_in * off_in;
  assign smag = osum[SUM_W-1] ? SUM_W'(-osum) : SUM_W'(osum);

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      offset_ring[wptr] <= off_in;
      time_ring[wptr] <= t_in;
    end
    rd_off <= offset_ring[rd_addr];
    rd_time <= time_ring[rd_addr];
  end

  cows_serial_mul u_mul (.clk, .rst, .start(mul_start), .a(ma), .b(mb),
    .busy(mul_busy), .p(mp));
  cows_serial_div u_div (.clk, .rst, .start(div_start), .num(dnum), .den(dden),
    .busy(div_busy), .quo(dq));
  cows_serial_sqrt u_sqrt (.clk, .rst, .start(sqrt_start), .x(work),
    .busy(sqrt_busy), .root(root));

  assign mul_idle = !mul_start && !mul_busy;
  assign div_idle = !div_start && !div_busy;
  assign sqrt_idle = !sqrt_start && !sqrt_busy;

  assign in_s.ready = (state == S_IDLE) && !out_s.valid;

  // one-cycle start pulses, raised on the edge that enters the waiting state
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      sqrt_start <= 1'b0;
    end else begin
      mul_start <= (state == S_WAIT) || (state == S_SQ1 && mul_idle) ||
                   (state == S_SQ2 && mul_idle);
      div_start <= (state == S_DIFF && mul_idle && span_ok) ||
                   (state == S_SQRT && sqrt_idle);
      sqrt_start <= (state == S_DIFF && mul_idle && !span_ok) ||
                    (state == S_DRIFT && div_idle);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wptr <= '0;
      count <= '0;
      osum <= '0;
      sqsum <= '0;
      out_s.valid <= 1'b0;
    end else begin
      if (out_s.valid && out_s.ready) out_s.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_s.valid && in_s.ready) begin
          off_in <= in_s.data[OFF_W-1:0];
          t_in <= in_s.data[OFF_W+TIME_W-1:OFF_W];
          rd_addr <= wptr;
          state <= S_RDOLD;
        end
        S_RDOLD: state <= S_UPD;
        S_UPD: begin
          if (full) begin
            osum <= osum - SUM_W'(rd_off) + SUM_W'(off_in);
            sqsum <= sqsum - SQ_W'(oldsq) + SQ_W'(newsq);
          end else begin
            osum <= osum + SUM_W'(off_in);
            sqsum <= sqsum + SQ_W'(newsq);
            count <= count + CNT_W'(1);
          end
          // oldest after the write: next slot when full, slot zero otherwise
          if (full) rd_addr <= (wptr == PTR_W'(WINDOW - 1)) ? '0 : wptr + PTR_W'(1);
          else rd_addr <= '0;
          wptr <= (wptr == PTR_W'(WINDOW - 1)) ? '0 : wptr + PTR_W'(1);
          state <= S_RDOST;
        end
        S_RDOST: state <= S_WAIT;
        S_WAIT: begin
          delta <= MAG_W'(off_in) - MAG_W'(rd_off);
          span_ok <= (count >= CNT_W'(2)) && (t_in >= rd_time) &&
                     (t_in - rd_time >= MIN_SPAN);
          dden <= t_in - rd_time;
          ma <= VAR_W'(sqsum);
          mb <= SQRT_W'(count);
          state <= S_SQ1;
        end
        S_SQ1: if (mul_idle) begin
          nsq <= mp;
          ma <= VAR_W'(smag);
          mb <= SQRT_W'(smag);
          state <= S_SQ2;
        end
        S_SQ2: if (mul_idle) begin
          ssq <= mp;
          neg <= delta[MAG_W-1];
          ma <= delta[MAG_W-1] ? VAR_W'(-delta) : VAR_W'(delta);
          mb <= SQRT_W'(NS_PER_S);
          state <= S_DIFF;
        end
        S_DIFF: if (mul_idle) begin
          work <= nsq - ssq;
          drift <= '0;
          if (span_ok) begin
            dnum <= mp;
            state <= S_DRIFT;
          end else begin
            state <= S_SQRT;
          end
        end
        S_DRIFT: if (div_idle) begin
          drift <= neg ? DRIFT_W'(-dq) : DRIFT_W'(dq);
          state <= S_SQRT;
        end
        S_SQRT: if (sqrt_idle) begin
          dnum <= VAR_W'(root);
          dden <= TIME_W'(count);
          state <= S_JDIV;
        end
        S_JDIV: if (div_idle) begin
          jit <= JIT_W'(dq);
          state <= S_OUT;
        end
        S_OUT: begin
          out_s.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_s.data = {WCNT_W'(count), jit, drift};

  `COWS_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, !in_s.ready)
  `COWS_ASSERT_NXT(a_out_after_fin, clk, rst, state == S_OUT, out_s.valid)
  `COWS_ASSERT_IMP(a_count_range, clk, rst, out_s.valid, count != '0 && count <= CNT_W'(WINDOW))
endmodule

### hw/rtl/cows_serial_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle
module cows_serial_mul import cows_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [VAR_W-1:0] a,
  input  logic [SQRT_W-1:0] b,
  output logic busy,
  output logic [VAR_W-1:0] p
);
  logic [VAR_W-1:0] acc, mcand;
  logic [SQRT_W-1:0] mplier;
  logic [6:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'(SQRT_W);
      acc <= '0;
      mcand <= a;
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand <= mcand << 1;
      mplier <= mplier >> 1;
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
  assign p = acc;
endmodule

### hw/rtl/cows_serial_div.sv
// Restoring divider, one quotient bit per cycle
module cows_serial_div import cows_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [VAR_W-1:0] num,
  input  logic [TIME_W-1:0] den,
  output logic busy,
  output logic [VAR_W-1:0] quo
);
  logic [VAR_W-1:0] q;
  logic [TIME_W:0] rem;
  logic [TIME_W:0] trial;
  logic [6:0] cnt;

  assign trial = {rem[TIME_W-1:0], q[VAR_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'(VAR_W);
      q <= num;
      rem <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        q <= {q[VAR_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[VAR_W-2:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
  assign quo = q;
endmodule

### hw/rtl/cows_serial_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle
module cows_serial_sqrt import cows_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [VAR_W-1:0] x,
  output logic busy,
  output logic [SQRT_W-1:0] root
);
  logic [VAR_W-1:0] rad;
  logic [SQRT_W+1:0] rem, trial;
  logic [SQRT_W-1:0] r;
  logic [SQRT_W+1:0] shifted;
  logic [6:0] cnt;

  assign shifted = {rem[SQRT_W-1:0], rad[VAR_W-1:VAR_W-2]};
  assign trial = {r, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'(VAR_W / 2);
      rad <= x;
      rem <= '0;
      r <= '0;
    end else if (busy) begin
      rad <= rad << 2;
      if (shifted >= trial) begin
        rem <= shifted - trial;
        r <= {r[SQRT_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        r <= {r[SQRT_W-2:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
  assign root = r;
endmodule
